/* hw/rtl/sd_spi_init_sequencer_assert.svh */
// assertion helpers for the sd spi start-up sequencer checker
`ifndef SD_SPI_INIT_SEQUENCER_ASSERT_SVH
`define SD_SPI_INIT_SEQUENCER_ASSERT_SVH

// same-cycle implication, sampled on clk, quiet during reset
`define SDI_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sdi check failed");

// next-cycle implication, sampled on clk, quiet during reset
`define SDI_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sdi check failed");

`endif

/* hw/rtl/sdi_pkg.sv */
package sdi_pkg;

    // sizes
    localparam int CNT_W     = 7;
    localparam int TIMER_W   = 16;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 1;

    // polling and wake-up lengths in bytes
    localparam int POLL_LIMIT = 100;
    localparam int WAKE_BYTES = 10;

    localparam logic [CNT_W-1:0] POLL_MAX     = CNT_W'(POLL_LIMIT);
    localparam logic [CNT_W-1:0] WAKE_MAX     = CNT_W'(WAKE_BYTES);
    localparam logic [CNT_W-1:0] FRAME_LEN    = 7'd6;
    localparam logic [CNT_W-1:0] TAIL_LEN     = 7'd4;
    localparam logic [CNT_W-1:0] OCR_TOP_BYTE = 7'd1;

    // configuration register indexes and reset values
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_TIMEOUT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BUSY_TIMEOUT = 1'd1;
    localparam logic [CFG_W-1:0]     INIT_TIMEOUT_RST = 16'd2000;
    localparam logic [CFG_W-1:0]     BUSY_TIMEOUT_RST = 16'd600;

    // request function codes
    localparam logic [1:0] FUNC_START = 2'd0;
    localparam logic [1:0] FUNC_BYTE  = 2'd1;
    localparam logic [1:0] FUNC_TICK  = 2'd2;

    // card types
    localparam logic [1:0] CT_NONE = 2'd0;
    localparam logic [1:0] CT_SD1  = 2'd1;
    localparam logic [1:0] CT_SD2  = 2'd2;
    localparam logic [1:0] CT_SDHC = 2'd3;

    // bytes on the wire
    localparam logic [7:0]  IDLE_FILL     = 8'hFF;
    localparam logic [7:0]  R1_IDLE       = 8'h01;
    localparam logic [7:0]  R1_ILLEGAL    = 8'h05;
    localparam logic [7:0]  R1_READY      = 8'h00;
    localparam logic [7:0]  CHECK_ECHO    = 8'hAA;
    localparam logic [7:0]  OCR_CCS_MASK  = 8'hC0;
    localparam logic [7:0]  CMD_START     = 8'h40;
    localparam logic [7:0]  CRC_CMD0      = 8'h95;
    localparam logic [7:0]  CRC_CMD8      = 8'h87;
    localparam logic [31:0] CMD8_ARG      = 32'h0000_01AA;
    localparam logic [31:0] HCS_ARG       = 32'h4000_0000;

    // command indexes
    localparam logic [5:0] CMD_GO_IDLE     = 6'd0;
    localparam logic [5:0] CMD_SEND_IF     = 6'd8;
    localparam logic [5:0] ACMD_OP_COND    = 6'd41;
    localparam logic [5:0] CMD_APP         = 6'd55;
    localparam logic [5:0] CMD_READ_OCR    = 6'd58;

    typedef enum logic [1:0] {MODE_IDLE, MODE_WAKE, MODE_CMD} mode_t;
    typedef enum logic [1:0] {ST_CMD0, ST_CMD8, ST_ACMD, ST_CMD58} stage_t;
    typedef enum logic [1:0] {SUB_BUSY, SUB_FRAME, SUB_POLL, SUB_TAIL} sub_t;
    typedef enum logic [1:0] {END_NONE, END_OK, END_FAIL} end_t;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] rx_byte;
    } item_t;

    typedef struct packed {
        logic       send_valid;
        logic [7:0] send_byte;
        logic       select_low;
        logic       finished;
        logic       init_ok;
        logic [1:0] card_type;
    } result_t;

    // byte idx of the six-byte command frame for a stage
    function automatic logic [7:0] frame_byte(stage_t stage, logic [2:0] idx,
                                              logic app_sent, logic [1:0] dtype);
        logic [5:0]  cmd;
        logic [31:0] arg;
        logic [7:0]  crc;
        logic [7:0]  b;
        cmd = CMD_GO_IDLE;
        arg = '0;
        crc = IDLE_FILL;
        case (stage)
            ST_CMD0: crc = CRC_CMD0;
            ST_CMD8:
            begin
                cmd = CMD_SEND_IF;
                arg = CMD8_ARG;
                crc = CRC_CMD8;
            end
            ST_ACMD:
            begin
                cmd = app_sent ? ACMD_OP_COND : CMD_APP;
                if (app_sent && dtype == CT_SD2)
                begin
                    arg = HCS_ARG;
                end
            end
            ST_CMD58: cmd = CMD_READ_OCR;
            default: cmd = CMD_GO_IDLE;
        endcase
        case (idx)
            3'd0: b = CMD_START | {2'b00, cmd};
            3'd1: b = arg[31:24];
            3'd2: b = arg[23:16];
            3'd3: b = arg[15:8];
            3'd4: b = arg[7:0];
            default: b = crc;
        endcase
        return b;
    endfunction

endpackage

/* hw/rtl/sdi_chan_if.sv */
// request channel into the sequencer
interface sdi_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic [7:0] rx_byte;

    modport source (output valid, output func, output rx_byte, input ready);
    modport sink (input valid, input func, input rx_byte, output ready);
endinterface

// result channel out of the sequencer
interface sdi_out_if;
    logic       valid;
    logic       ready;
    logic       send_valid;
    logic [7:0] send_byte;
    logic       select_low;
    logic       finished;
    logic       init_ok;
    logic [1:0] card_type;

    modport source (output valid, output send_valid, output send_byte, output select_low,
                    output finished, output init_ok, output card_type, input ready);
    modport sink (input valid, input send_valid, input send_byte, input select_low,
                  input finished, input init_ok, input card_type, output ready);
endinterface

/* hw/rtl/sd_spi_init_sequencer.sv */
// an accepted request is held in the input register, its result is captured in the result register (2 stages)
// throughput: one request per cycle while the sink takes results, set by the state update in sdi_core
// a new request is taken while a finished result still waits in the result register
// reset (rst_n low, asynchronous): sequencer idle, counters and card type cleared,
// init timeout 2000 ms and busy timeout 600 ms, both pipeline stages empty
module sd_spi_init_sequencer (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wen,
    input  logic [sdi_pkg::CFG_IDX_W-1:0] cfg_idx,
    input  logic [sdi_pkg::CFG_W-1:0]     cfg_data,
    sdi_in_if.sink                        in_ch,
    sdi_out_if.source                     out_ch
);
    import sdi_pkg::*;

    // step: the held request moves into the core and its result is captured
    logic    step;
    // out_free: the result register can take a new result this cycle
    logic    out_free;
    item_t   item;
    result_t result;

    // input register; ready stays high as long as the held request can move on
    sdi_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ch    (in_ch),
        .out_free (out_free),
        .step     (step),
        .item     (item)
    );

    // start-up state machine: wake bytes, then cmd0, cmd8, cmd55/acmd41, cmd58 for version 2 cards,
    // each command as busy wait, six frame bytes, response poll and, for cmd8 and cmd58, trailing bytes;
    // timeout registers live here too
    sdi_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_wen  (cfg_wen),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data),
        .step     (step),
        .item     (item),
        .result   (result)
    );

    // result register; holds the result until the sink takes it
    sdi_out_stage u_out_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .result   (result),
        .out_free (out_free),
        .out_ch   (out_ch)
    );

endmodule

/* hw/rtl/sdi_in_stage.sv */
module sdi_in_stage (
    input  logic          clk,
    input  logic          rst_n,
    sdi_in_if.sink        in_ch,
    input  logic          out_free,
    output logic          step,
    output sdi_pkg::item_t item
);
    import sdi_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  take;

    assign step        = valid_reg && out_free;
    assign in_ch.ready = !valid_reg || out_free;
    assign take        = in_ch.valid && in_ch.ready;
    assign item        = item_reg;

    always_comb
    begin
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (step)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= '{func: in_ch.func, rx_byte: in_ch.rx_byte};
        end
    end

endmodule

/* hw/rtl/sdi_core.sv */
module sdi_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wen,
    input  logic [sdi_pkg::CFG_IDX_W-1:0]   cfg_idx,
    input  logic [sdi_pkg::CFG_W-1:0]       cfg_data,
    input  logic                            step,
    input  sdi_pkg::item_t                  item,
    output sdi_pkg::result_t                result
);
    import sdi_pkg::*;

    mode_t              mode_reg, mode_next;
    stage_t             stage_reg, stage_next;
    sub_t               sub_reg, sub_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [TIMER_W-1:0] elapsed_reg, elapsed_next;
    logic [TIMER_W-1:0] busy_reg, busy_next;
    logic [1:0]         dtype_reg, dtype_next;
    logic               app_reg, app_next;
    logic [CFG_W-1:0]   init_to_reg;
    logic [CFG_W-1:0]   busy_to_reg;

    end_t               end_code;
    logic               go_busy;
    stage_t             go_stage;
    logic [CNT_W-1:0]   cnt_inc;
    logic               timed_out;
    logic               busy_over;
    logic [7:0]         rx;

    assign cnt_inc   = cnt_reg + 7'd1;
    assign timed_out = elapsed_reg > init_to_reg;
    assign busy_over = busy_reg > busy_to_reg;
    assign rx        = item.rx_byte;

    // next state for one request
    always_comb
    begin
        mode_next    = mode_reg;
        stage_next   = stage_reg;
        sub_next     = sub_reg;
        cnt_next     = cnt_reg;
        elapsed_next = elapsed_reg;
        busy_next    = busy_reg;
        dtype_next   = dtype_reg;
        app_next     = app_reg;
        end_code     = END_NONE;
        go_busy      = 1'b0;
        go_stage     = ST_CMD0;

        case (item.func)
            FUNC_START:
            begin
                mode_next    = MODE_WAKE;
                cnt_next     = '0;
                elapsed_next = '0;
                busy_next    = '0;
                dtype_next   = CT_NONE;
                app_next     = 1'b0;
            end
            FUNC_BYTE:
            begin
                if (mode_reg == MODE_WAKE)
                begin
                    cnt_next = cnt_inc;
                    if (cnt_inc >= WAKE_MAX)
                    begin
                        elapsed_next = '0;
                        go_busy      = 1'b1;
                        go_stage     = ST_CMD0;
                    end
                end
                else if (mode_reg == MODE_CMD)
                begin
                    case (sub_reg)
                        SUB_BUSY:
                        begin
                            if (rx == IDLE_FILL || busy_over)
                            begin
                                sub_next = SUB_FRAME;
                                cnt_next = '0;
                            end
                        end
                        SUB_FRAME:
                        begin
                            cnt_next = cnt_inc;
                            if (cnt_inc >= FRAME_LEN)
                            begin
                                sub_next = SUB_POLL;
                                cnt_next = '0;
                            end
                        end
                        SUB_POLL:
                        begin
                            cnt_next = cnt_inc;
                            if (!rx[7] || cnt_inc >= POLL_MAX)
                            begin
                                case (stage_reg)
                                    ST_CMD0:
                                    begin
                                        if (rx == R1_IDLE)
                                        begin
                                            go_busy  = 1'b1;
                                            go_stage = ST_CMD8;
                                        end
                                        else if (timed_out)
                                        begin
                                            end_code = END_FAIL;
                                        end
                                        else
                                        begin
                                            go_busy  = 1'b1;
                                            go_stage = ST_CMD0;
                                        end
                                    end
                                    ST_CMD8:
                                    begin
                                        if (rx == R1_ILLEGAL)
                                        begin
                                            dtype_next = CT_SD1;
                                            app_next   = 1'b0;
                                            go_busy    = 1'b1;
                                            go_stage   = ST_ACMD;
                                        end
                                        else
                                        begin
                                            sub_next = SUB_TAIL;
                                            cnt_next = '0;
                                        end
                                    end
                                    ST_ACMD:
                                    begin
                                        if (!app_reg)
                                        begin
                                            app_next = 1'b1;
                                            go_busy  = 1'b1;
                                            go_stage = ST_ACMD;
                                        end
                                        else
                                        begin
                                            app_next = 1'b0;
                                            if (rx == R1_READY)
                                            begin
                                                if (dtype_reg == CT_SD2)
                                                begin
                                                    go_busy  = 1'b1;
                                                    go_stage = ST_CMD58;
                                                end
                                                else
                                                begin
                                                    end_code = END_OK;
                                                end
                                            end
                                            else if (timed_out)
                                            begin
                                                end_code = END_FAIL;
                                            end
                                            else
                                            begin
                                                go_busy  = 1'b1;
                                                go_stage = ST_ACMD;
                                            end
                                        end
                                    end
                                    default:
                                    begin
                                        if (rx != R1_READY)
                                        begin
                                            end_code = END_FAIL;
                                        end
                                        else
                                        begin
                                            sub_next = SUB_TAIL;
                                            cnt_next = '0;
                                        end
                                    end
                                endcase
                            end
                        end
                        default:
                        begin
                            // trailing bytes of the r7 or r3 response
                            cnt_next = cnt_inc;
                            if (stage_reg == ST_CMD8)
                            begin
                                if (cnt_inc >= TAIL_LEN)
                                begin
                                    if (rx == CHECK_ECHO)
                                    begin
                                        dtype_next = CT_SD2;
                                        app_next   = 1'b0;
                                        go_busy    = 1'b1;
                                        go_stage   = ST_ACMD;
                                    end
                                    else if (timed_out)
                                    begin
                                        end_code = END_FAIL;
                                    end
                                    else
                                    begin
                                        go_busy  = 1'b1;
                                        go_stage = ST_CMD8;
                                    end
                                end
                            end
                            else
                            begin
                                if (cnt_inc == OCR_TOP_BYTE &&
                                    (rx & OCR_CCS_MASK) == OCR_CCS_MASK)
                                begin
                                    dtype_next = CT_SDHC;
                                end
                                if (cnt_inc >= TAIL_LEN)
                                begin
                                    end_code = END_OK;
                                end
                            end
                        end
                    endcase
                end
            end
            FUNC_TICK:
            begin
                if (mode_reg == MODE_CMD)
                begin
                    if (elapsed_reg != '1)
                    begin
                        elapsed_next = elapsed_reg + 16'd1;
                    end
                    if (busy_reg != '1)
                    begin
                        busy_next = busy_reg + 16'd1;
                    end
                end
            end
            default:
            begin
                mode_next = mode_reg;
            end
        endcase

        if (go_busy)
        begin
            mode_next  = MODE_CMD;
            stage_next = go_stage;
            sub_next   = SUB_BUSY;
            cnt_next   = '0;
            busy_next  = '0;
        end

        if (end_code != END_NONE)
        begin
            mode_next = MODE_IDLE;
            cnt_next  = '0;
        end
    end

    // result built from the state just reached
    always_comb
    begin
        result.send_valid = (end_code != END_NONE) || (mode_next != MODE_IDLE);
        result.select_low = (end_code == END_NONE) && (mode_next == MODE_CMD);
        if (end_code == END_NONE && mode_next == MODE_CMD && sub_next == SUB_FRAME)
        begin
            result.send_byte = frame_byte(stage_next, cnt_next[2:0], app_next, dtype_next);
        end
        else
        begin
            result.send_byte = IDLE_FILL;
        end
        result.finished  = end_code != END_NONE;
        result.init_ok   = end_code == END_OK;
        result.card_type = dtype_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_IDLE;
            stage_reg   <= ST_CMD0;
            sub_reg     <= SUB_BUSY;
            cnt_reg     <= '0;
            elapsed_reg <= '0;
            busy_reg    <= '0;
            dtype_reg   <= CT_NONE;
            app_reg     <= 1'b0;
        end
        else if (step)
        begin
            mode_reg    <= mode_next;
            stage_reg   <= stage_next;
            sub_reg     <= sub_next;
            cnt_reg     <= cnt_next;
            elapsed_reg <= elapsed_next;
            busy_reg    <= busy_next;
            dtype_reg   <= dtype_next;
            app_reg     <= app_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_to_reg <= INIT_TIMEOUT_RST;
            busy_to_reg <= BUSY_TIMEOUT_RST;
        end
        else if (cfg_wen)
        begin
            if (cfg_idx == CFG_INIT_TIMEOUT)
            begin
                init_to_reg <= cfg_data;
            end
            if (cfg_idx == CFG_BUSY_TIMEOUT)
            begin
                busy_to_reg <= cfg_data;
            end
        end
    end

endmodule

/* hw/rtl/sdi_out_stage.sv */
module sdi_out_stage (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  sdi_pkg::result_t result,
    output logic             out_free,
    sdi_out_if.source        out_ch
);
    import sdi_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign out_free = !valid_reg || out_ch.ready;

    always_comb
    begin
        if (step)
        begin
            valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            res_reg <= result;
        end
    end

    assign out_ch.valid      = valid_reg;
    assign out_ch.send_valid = res_reg.send_valid;
    assign out_ch.send_byte  = res_reg.send_byte;
    assign out_ch.select_low = res_reg.select_low;
    assign out_ch.finished   = res_reg.finished;
    assign out_ch.init_ok    = res_reg.init_ok;
    assign out_ch.card_type  = res_reg.card_type;

endmodule

/* hw/rtl/sdi_checker.sv */
`include "sd_spi_init_sequencer_assert.svh"

module sdi_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic       send_valid,
    input logic [7:0] send_byte,
    input logic       select_low,
    input logic       finished,
    input logic       init_ok,
    input logic [1:0] card_type
);
    import sdi_pkg::*;

    // a stalled result holds
    `SDI_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(send_valid) && $stable(send_byte) && $stable(select_low) && $stable(finished) && $stable(init_ok) && $stable(card_type))

    // the closing exchange is a plain fill byte with the card deselected
    `SDI_ASSERT_IMPL(a_done_frame, out_valid && finished, send_valid && !select_low && send_byte == IDLE_FILL)

    // success only on the closing result and only with a known card
    `SDI_ASSERT_IMPL(a_ok_known, out_valid && init_ok, finished && card_type != CT_NONE)

    // chip select low only with an exchange requested
    `SDI_ASSERT_IMPL(a_sel_valid, out_valid && select_low, send_valid)

endmodule

bind sd_spi_init_sequencer sdi_checker u_sdi_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .send_valid (out_ch.send_valid),
    .send_byte  (out_ch.send_byte),
    .select_low (out_ch.select_low),
    .finished   (out_ch.finished),
    .init_ok    (out_ch.init_ok),
    .card_type  (out_ch.card_type)
);

/* verif/tb_top.sv */
module tb_top;
    import sdi_pkg::*;

    // function code that the block has no use for
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    // one request plus its pacing marks
    typedef struct {
        item_t req;
        bit    rush;   // no idling on either side
        bit    drain;  // held back until every result is in
    } card_req_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_wen;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0]     cfg_data;

    sdi_in_if  in_ch ();
    sdi_out_if out_ch ();

    sd_spi_init_sequencer dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_wen  (cfg_wen),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data),
        .in_ch    (in_ch),
        .out_ch   (out_ch)
    );

    // 4 time unit clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // sequencer state as the block should hold it
    // ------------------------------------------------------------------
    mode_t       seq_mode;
    stage_t      seq_stage;
    sub_t        seq_sub;
    logic [6:0]  seq_count;
    logic [15:0] ms_elapsed;
    logic [15:0] ms_busy;
    logic [1:0]  seq_type;
    logic [7:0]  seq_r1;
    logic        seq_app;
    logic [15:0] init_limit;
    logic [15:0] busy_limit;

    // bookkeeping for requests and results
    card_req_t card_traffic[$];       // requests not yet offered
    result_t   sequencer_results[$];  // results owed by the block, oldest first
    card_req_t staged_req;            // next request, sitting out its gap
    card_req_t shown_req;             // request on the channel now
    bit        staged;
    bit        in_calm;
    bit        out_calm;
    bit        rush_on;
    bit        noisy;
    int        gap_left;
    int        stall_left;
    int        mismatches;
    int        results_seen;
    int        queued_items;
    logic      in_valid_nx;
    logic      out_ready_nx;

    // wipe the run state; start request and reset share this
    function automatic void restart_sequencer(mode_t m);
        seq_mode   = m;
        seq_stage  = ST_CMD0;
        seq_sub    = SUB_BUSY;
        seq_count  = '0;
        ms_elapsed = '0;
        ms_busy    = '0;
        seq_type   = CT_NONE;
        seq_r1     = '0;
        seq_app    = 1'b0;
    endfunction

    function automatic void go_to(stage_t s, sub_t u);
        seq_mode  = MODE_CMD;
        seq_stage = s;
        seq_sub   = u;
        seq_count = '0;
    endfunction

    // every command starts by waiting out a busy card
    function automatic void enter_busy(stage_t s);
        go_to(s, SUB_BUSY);
        ms_busy = '0;
    endfunction

    function automatic bit past_deadline();
        return ms_elapsed > init_limit;
    endfunction

    // byte idx of the six-byte command frame of the current stage
    function automatic logic [7:0] command_byte(logic [6:0] idx);
        logic [5:0]  cmd;
        logic [31:0] arg;
        cmd = CMD_GO_IDLE;
        arg = '0;
        if (seq_stage == ST_CMD8)
        begin
            cmd = CMD_SEND_IF;
            arg = CMD8_ARG;
        end
        else if (seq_stage == ST_ACMD)
        begin
            cmd = seq_app ? ACMD_OP_COND : CMD_APP;
            // high capacity support only offered to version 2 cards
            if (seq_app && seq_type == CT_SD2)
                arg = HCS_ARG;
        end
        else if (seq_stage == ST_CMD58)
        begin
            cmd = CMD_READ_OCR;
        end
        if (idx == 0)
            return CMD_START | {2'b00, cmd};
        if (idx <= 4)
            return 8'(arg >> (8 * (4 - idx)));
        if (cmd == CMD_GO_IDLE)
            return CRC_CMD0;
        if (cmd == CMD_SEND_IF)
            return CRC_CMD8;
        return IDLE_FILL;
    endfunction

    // decide on the r1 response that ended a poll
    function automatic end_t judge_r1();
        end_t e;
        e = END_NONE;
        case (seq_stage)
            ST_CMD0:
            begin
                if (seq_r1 == R1_IDLE)
                    enter_busy(ST_CMD8);
                else if (past_deadline())
                    e = END_FAIL;
                else
                    enter_busy(ST_CMD0);
            end
            ST_CMD8:
            begin
                // illegal command marks a version 1 card, else read the echo
                if (seq_r1 == R1_ILLEGAL)
                begin
                    seq_type = CT_SD1;
                    seq_app  = 1'b0;
                    enter_busy(ST_ACMD);
                end
                else
                begin
                    go_to(ST_CMD8, SUB_TAIL);
                end
            end
            ST_ACMD:
            begin
                if (!seq_app)
                begin
                    // cmd55 answer carries nothing of interest
                    seq_app = 1'b1;
                    enter_busy(ST_ACMD);
                end
                else
                begin
                    seq_app = 1'b0;
                    if (seq_r1 == R1_READY)
                    begin
                        if (seq_type == CT_SD2)
                            enter_busy(ST_CMD58);
                        else
                            e = END_OK;
                    end
                    else if (past_deadline())
                    begin
                        e = END_FAIL;
                    end
                    else
                    begin
                        enter_busy(ST_ACMD);
                    end
                end
            end
            default:
            begin
                if (seq_r1 != R1_READY)
                    e = END_FAIL;
                else
                    go_to(ST_CMD58, SUB_TAIL);
            end
        endcase
        return e;
    endfunction

    // a byte came back from the card
    function automatic end_t take_byte(logic [7:0] rx);
        end_t e;
        e = END_NONE;
        if (seq_mode == MODE_WAKE)
        begin
            seq_count++;
            if (seq_count >= WAKE_MAX)
            begin
                ms_elapsed = '0;
                enter_busy(ST_CMD0);
            end
            return END_NONE;
        end
        if (seq_mode != MODE_CMD)
            return END_NONE;
        case (seq_sub)
            SUB_BUSY:
            begin
                // busy wait gives up once its allowance is spent
                if (rx == IDLE_FILL || ms_busy > busy_limit)
                    go_to(seq_stage, SUB_FRAME);
            end
            SUB_FRAME:
            begin
                seq_count++;
                if (seq_count >= FRAME_LEN)
                    go_to(seq_stage, SUB_POLL);
            end
            SUB_POLL:
            begin
                // an exhausted poll is judged on its last byte
                seq_r1 = rx;
                seq_count++;
                if (!rx[7] || seq_count >= POLL_MAX)
                    e = judge_r1();
            end
            default:
            begin
                seq_count++;
                if (seq_stage == ST_CMD8)
                begin
                    if (seq_count >= TAIL_LEN)
                    begin
                        if (rx == CHECK_ECHO)
                        begin
                            seq_type = CT_SD2;
                            seq_app  = 1'b0;
                            enter_busy(ST_ACMD);
                        end
                        else if (past_deadline())
                        begin
                            e = END_FAIL;
                        end
                        else
                        begin
                            enter_busy(ST_CMD8);
                        end
                    end
                end
                else
                begin
                    // ocr top byte tells sdhc apart
                    if (seq_count == OCR_TOP_BYTE && (rx & OCR_CCS_MASK) == OCR_CCS_MASK)
                        seq_type = CT_SDHC;
                    if (seq_count >= TAIL_LEN)
                        e = END_OK;
                end
            end
        endcase
        return e;
    endfunction

    // one accepted request in, the result it owes out
    function automatic result_t advance_sequencer(item_t it);
        end_t    e;
        result_t r;
        e = END_NONE;
        if (it.func == FUNC_START)
        begin
            restart_sequencer(MODE_WAKE);
        end
        else if (it.func == FUNC_BYTE)
        begin
            e = take_byte(it.rx_byte);
        end
        else if (it.func == FUNC_TICK && seq_mode == MODE_CMD)
        begin
            // both timers saturate
            if (ms_elapsed != 16'hFFFF)
                ms_elapsed++;
            if (ms_busy != 16'hFFFF)
                ms_busy++;
        end
        r.send_valid = 1'b0;
        r.send_byte  = IDLE_FILL;
        r.select_low = 1'b0;
        r.finished   = e != END_NONE;
        r.init_ok    = e == END_OK;
        if (e != END_NONE)
        begin
            // one last exchange with chip select high
            seq_mode     = MODE_IDLE;
            seq_count    = '0;
            r.send_valid = 1'b1;
        end
        else if (seq_mode == MODE_WAKE)
        begin
            r.send_valid = 1'b1;
        end
        else if (seq_mode == MODE_CMD)
        begin
            r.send_valid = 1'b1;
            r.select_low = 1'b1;
            if (seq_sub == SUB_FRAME)
                r.send_byte = command_byte(seq_count);
        end
        r.card_type = seq_type;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------
    task automatic report(string what, logic [7:0] got, logic [7:0] want);
        if (mismatches < 40)
            $display("mismatch on %0s at result %0d: got %0h, want %0h",
                     what, results_seen, got, want);
        mismatches++;
    endtask

    task automatic compare_field(string what, logic [7:0] got, logic [7:0] want);
        if (got !== want)
            report(what, got, want);
    endtask

    task automatic check_result();
        result_t want;
        if (sequencer_results.size() == 0)
        begin
            report("unrequested result", out_ch.send_byte, 8'h00);
            return;
        end
        want = sequencer_results.pop_front();
        compare_field("send_valid", 8'(out_ch.send_valid), 8'(want.send_valid));
        compare_field("send_byte", out_ch.send_byte, want.send_byte);
        compare_field("select_low", 8'(out_ch.select_low), 8'(want.select_low));
        compare_field("finished", 8'(out_ch.finished), 8'(want.finished));
        compare_field("init_ok", 8'(out_ch.init_ok), 8'(want.init_ok));
        compare_field("card_type", 8'(out_ch.card_type), 8'(want.card_type));
        results_seen++;
    endtask

    // ------------------------------------------------------------------
    // request driver: pops the queue and may idle before each request
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid   <= 1'b0;
            in_ch.func    <= FUNC_TICK;
            in_ch.rx_byte <= '0;
            staged   = 1'b0;
            gap_left = 0;
        end
        else
        begin
            in_valid_nx = in_ch.valid;
            // accepted request goes through the prediction right away
            if (in_ch.valid && in_ch.ready)
            begin
                sequencer_results.push_back(advance_sequencer(shown_req.req));
                in_valid_nx = 1'b0;
            end
            if (!staged && card_traffic.size() != 0)
            begin
                staged_req = card_traffic.pop_front();
                staged     = 1'b1;
                // occasional stretches without gaps
                if ($urandom_range(0, 149) == 0)
                    in_calm = !in_calm;
                gap_left = (staged_req.rush || in_calm) ? 0 : $urandom_range(0, 12);
            end
            if (!in_valid_nx && staged)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                end
                else if (!staged_req.drain || sequencer_results.size() == 0)
                begin
                    // a drain request waits until the block has caught up
                    shown_req   = staged_req;
                    staged      = 1'b0;
                    rush_on     = staged_req.rush;
                    in_valid_nx = 1'b1;
                    in_ch.func    <= staged_req.req.func;
                    in_ch.rx_byte <= staged_req.req.rx_byte;
                end
            end
            in_ch.valid <= in_valid_nx;
        end
    end

    // ------------------------------------------------------------------
    // result monitor: checks each result and may stall after each
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            out_ready_nx = out_ch.ready;
            if (out_ch.valid && out_ch.ready)
            begin
                check_result();
                if ($urandom_range(0, 149) == 0)
                    out_calm = !out_calm;
                stall_left   = (rush_on || out_calm) ? 0 : $urandom_range(0, 12);
                out_ready_nx = 1'b0;
            end
            if (!out_ready_nx)
            begin
                if (stall_left > 0)
                    stall_left--;
                else
                    out_ready_nx = 1'b1;
            end
            out_ch.ready <= out_ready_nx;
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    task automatic add_item(logic [1:0] func, logic [7:0] rx, bit rush = 1'b0,
                            bit drain = 1'b0);
        card_req_t c;
        c.req.func    = func;
        c.req.rx_byte = rx;
        c.rush        = rush;
        c.drain       = drain;
        card_traffic.push_back(c);
        queued_items++;
    endtask

    // card byte, with ticks sprinkled in and, for noisy cards, junk requests
    task automatic add_byte(logic [7:0] rx);
        if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 4)) add_item(FUNC_TICK, 8'($urandom));
        if (noisy && $urandom_range(0, 11) == 0)
            add_item(2'($urandom_range(1, 3)), 8'($urandom));
        if (noisy && $urandom_range(0, 199) == 0)
            add_item(FUNC_START, 8'($urandom));
        add_item(FUNC_BYTE, rx);
    endtask

    // r1 style byte (bit 7 clear) that differs from the given one
    function automatic logic [7:0] other_r1(logic [7:0] avoid);
        logic [7:0] r;
        r = 8'($urandom_range(0, 127));
        if (r == avoid)
            r = r ^ 8'h02;
        return r;
    endfunction

    // busy bytes, six frame bytes, poll bytes, then the r1 answer unless the poll runs out
    task automatic run_command(logic [7:0] r1);
        repeat ($urandom_range(0, 3)) add_byte(8'($urandom_range(0, 254)));
        add_byte(IDLE_FILL);
        repeat (6) add_byte(8'($urandom));
        if ($urandom_range(0, 49) == 0)
        begin
            // card never answers: the poll runs out
            repeat (POLL_LIMIT) add_byte(8'($urandom) | 8'h80);
        end
        else
        begin
            repeat ($urandom_range(0, 4)) add_byte(8'($urandom) | 8'h80);
            add_byte(r1);
        end
    endtask

    // four trailing bytes after an r1 (cmd8 echo or ocr)
    task automatic run_tail(logic [7:0] first, logic [7:0] last);
        add_byte(first);
        add_byte(8'($urandom));
        add_byte(8'($urandom));
        add_byte(last);
    endtask

    // one card start-up as a card of a random flavor would answer it
    task automatic card_session(bit hold_first);
        int         flavor;
        logic [7:0] wrong_echo;
        flavor = $urandom_range(0, 4);  // sd1, sd2, sdhc, ocr error, stubborn card
        noisy  = $urandom_range(0, 4) == 0;
        add_item(FUNC_START, 8'($urandom), 1'b0, hold_first || $urandom_range(0, 3) == 0);
        repeat (WAKE_BYTES) add_byte(8'($urandom));
        repeat ($urandom_range(0, flavor == 4 ? 6 : 1)) run_command(other_r1(R1_IDLE));
        run_command(R1_IDLE);
        if (flavor == 0)
        begin
            run_command(R1_ILLEGAL);
        end
        else
        begin
            repeat ($urandom_range(0, 1))
            begin
                wrong_echo = 8'($urandom);
                if (wrong_echo == CHECK_ECHO)
                    wrong_echo = wrong_echo ^ 8'h01;
                run_command(other_r1(R1_ILLEGAL));
                run_tail(8'($urandom), wrong_echo);
            end
            run_command(R1_IDLE);
            run_tail(8'($urandom), CHECK_ECHO);
        end
        // cmd55 / acmd41 pairs until the card is ready
        repeat ($urandom_range(0, flavor == 4 ? 6 : 2))
        begin
            run_command(8'($urandom_range(0, 127)));
            run_command(R1_IDLE);
        end
        run_command(8'($urandom_range(0, 127)));
        run_command(R1_READY);
        if (flavor == 3)
        begin
            run_command(other_r1(R1_READY));
        end
        else if (flavor != 0)
        begin
            run_command(R1_READY);
            if (flavor == 2)
                run_tail(OCR_CCS_MASK | 8'($urandom), 8'($urandom));
            else if (flavor == 1)
                run_tail(8'($urandom) & 8'hBF, 8'($urandom));
            else
                run_tail(8'($urandom), 8'($urandom));
        end
        // closing exchange after the finished result
        add_byte(8'($urandom));
    endtask

    // wait until the block has nothing left to answer
    task automatic wait_quiet();
        @(posedge clk);
        while (card_traffic.size() != 0 || staged || in_ch.valid
               || sequencer_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        @(posedge clk);
        cfg_wen  <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_wen <= 1'b0;
        if (idx == CFG_INIT_TIMEOUT)
            init_limit = value;
        else
            busy_limit = value;
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        int p;
        int phase_start;
        logic [15:0] init_val;
        logic [15:0] busy_val;

        rst_n          = 1'b0;
        cfg_wen        = 1'b0;
        cfg_idx        = CFG_INIT_TIMEOUT;
        cfg_data       = '0;
        in_ch.valid    = 1'b0;
        in_ch.func     = FUNC_TICK;
        in_ch.rx_byte  = '0;
        out_ch.ready   = 1'b0;
        in_calm        = 1'b0;
        out_calm       = 1'b0;
        rush_on        = 1'b0;
        noisy          = 1'b0;
        mismatches     = 0;
        results_seen   = 0;
        queued_items   = 0;
        init_limit     = INIT_TIMEOUT_RST;
        busy_limit     = BUSY_TIMEOUT_RST;
        restart_sequencer(MODE_IDLE);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed: ignored requests while idle, restart, wake-up and the
        // first cmd0 frame under the reset timeouts
        add_item(FUNC_BYTE, 8'h00);
        add_item(FUNC_TICK, 8'hFF);
        add_item(FUNC_UNUSED, 8'h5A);
        add_item(FUNC_START, 8'hFF);
        add_item(FUNC_BYTE, 8'hFF);
        add_item(FUNC_BYTE, 8'h00);
        add_item(FUNC_TICK, 8'h00);
        add_item(FUNC_BYTE, 8'hA5);
        // start while running begins again, after the block caught up
        add_item(FUNC_START, 8'h00, 1'b0, 1'b1);
        for (int i = 0; i < WAKE_BYTES; i++)
            add_item(FUNC_BYTE, i[0] ? 8'hFF : 8'h00);
        add_item(FUNC_BYTE, 8'h00);     // card busy
        add_item(FUNC_TICK, 8'h3C);
        add_item(FUNC_BYTE, IDLE_FILL); // card free: frame follows
        repeat (3)
        begin
            add_item(FUNC_BYTE, 8'h55);
            add_item(FUNC_BYTE, 8'hAA);
        end
        wait_quiet();

        // busy allowance and start-up deadline both run out before the card answers
        write_reg(CFG_INIT_TIMEOUT, 16'd30);
        write_reg(CFG_BUSY_TIMEOUT, 16'd20);
        add_item(FUNC_START, 8'h00);
        repeat (WAKE_BYTES) add_item(FUNC_BYTE, 8'($urandom));
        repeat (40) add_item(FUNC_TICK, 8'($urandom), 1'b1);
        add_item(FUNC_BYTE, 8'h00);     // still busy, but allowance spent
        repeat (6) add_item(FUNC_BYTE, 8'($urandom));
        add_item(FUNC_BYTE, R1_READY);  // not idle and past the deadline
        add_item(FUNC_BYTE, 8'($urandom));
        wait_quiet();

        // random card sessions under several timeout settings
        for (p = 0; p < 6; p++)
        begin
            case (p)
                0:
                begin
                    init_val = INIT_TIMEOUT_RST;
                    busy_val = BUSY_TIMEOUT_RST;
                end
                1:
                begin
                    init_val = 16'hFFFF;
                    busy_val = 16'hFFFF;
                end
                2:
                begin
                    init_val = 16'd1;
                    busy_val = 16'd1;
                end
                3:
                begin
                    init_val = 16'($urandom_range(2, 60));
                    busy_val = 16'($urandom_range(1, 8));
                end
                4:
                begin
                    init_val = 16'd1;
                    busy_val = 16'hFFFF;
                end
                default:
                begin
                    init_val = 16'hFFFF;
                    busy_val = 16'd1;
                end
            endcase
            write_reg(CFG_INIT_TIMEOUT, init_val);
            write_reg(CFG_BUSY_TIMEOUT, busy_val);
            phase_start = queued_items;
            // first session of each setting waits for the block to drain
            card_session(1'b1);
            while (queued_items - phase_start < 200)
                card_session(1'b0);
            wait_quiet();
        end

        if (mismatches == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

    // watchdog
    initial
    begin
        #3000000;
        $display("tb_top failed");
        $finish;
    end

endmodule
